@@ rtl/spal_pkg.sv @@
// ---------------------------------------------------------------------------
// spal_pkg
// Shared constants and controller/datapath handshake types for the
// sweep-and-prune active list.
// ---------------------------------------------------------------------------
package spal_pkg;

  localparam int OBJ_W = 6;            // object index width
  localparam int CNT_W = 6;            // active_count field width
  localparam int OBJ_RANGE = 2 ** OBJ_W;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_END   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load_item;    // capture input word, clear index and overflow
    logic clear_all;    // empty the list and the seen-pair store
    logic list_rd;      // read active list at index (or index + 1)
    logic rd_next;      // select index + 1 as read address
    logic pair_latch;   // take list entry, issue seen-row read
    logic pair_commit;  // set pair bit, emit pair if new
    logic idx_inc;
    logic append;       // append object or flag overflow
    logic shift_wr;     // write list data back one slot lower
    logic size_dec;
    logic emit_sum;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_start;
    logic is_end;
    logic is_clear;
    logic more;         // index < size
    logic next_more;    // index + 1 < size
    logic match;        // list data equals object
    logic pair_new;     // pair not yet seen
    logic out_free;     // output register can take a word
  } status_t;

endpackage

@@ rtl/spal_if.sv @@
// ---------------------------------------------------------------------------
// spal_in_if / spal_out_if
// Valid/ready channels for endpoint words and result words.
// ---------------------------------------------------------------------------
interface spal_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                op;
  logic [spal_pkg::OBJ_W-1:0] object_index;

  modport source (output valid, op, object_index, input ready);
  modport sink   (input valid, op, object_index, output ready);
endinterface

interface spal_out_if;
  logic                      valid;
  logic                      ready;
  logic [spal_pkg::OBJ_W-1:0] first_index;
  logic [spal_pkg::OBJ_W-1:0] second_index;
  logic [spal_pkg::CNT_W-1:0] active_count;
  logic                      overflow;
  logic                      last;

  modport source (output valid, first_index, second_index, active_count, overflow, last,
                  input ready);
  modport sink   (input valid, first_index, second_index, active_count, overflow, last,
                  output ready);
endinterface

@@ rtl/sweep_prune_active_list_core.sv @@
// ---------------------------------------------------------------------------
// sweep_prune_active_list_core
// Sweep stage of a one-axis sweep-and-prune broad phase over sorted
// endpoint words.
// ---------------------------------------------------------------------------
// Input channel in_if: one endpoint word (op, object_index) per handshake.
// Output channel out_if: zero or more pair words, then one summary word
// with last set, carrying the list length and the overflow flag.
// One item is worked on at a time; in_if.ready is high only when idle.
// Steps per item, from acceptance until the summary enters the
// output register:
//   start : per entry, a list read and a seen-row read/update
//   end   : a compare per entry, a write and a read per shifted entry
//   clear / ignored word : dispatch, then the summary
// The registered read ports of the list and seen-pair RAMs set these steps.
// A single output register decouples the receiver: the summary waits there
// while the next word is accepted; a stall on a new pair holds the walk.
// Reset empties the list and marks every seen-pair row as unwritten
// through per-row flags, so no clearing pass is needed; a clear word does
// the same.
// ---------------------------------------------------------------------------
module sweep_prune_active_list_core #(
  parameter int MAX_OBJECTS  = 64,
  parameter int ACTIVE_SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  spal_in_if.sink     in_if,
  spal_out_if.source  out_if
);

  spal_pkg::cmd_t    cmd;
  spal_pkg::status_t sts;

  spal_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  spal_dp #(
    .MAX_OBJECTS  (MAX_OBJECTS),
    .ACTIVE_SLOTS (ACTIVE_SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_op            (in_if.op),
    .in_object_index  (in_if.object_index),
    .out_valid        (out_if.valid),
    .out_ready        (out_if.ready),
    .out_first_index  (out_if.first_index),
    .out_second_index (out_if.second_index),
    .out_active_count (out_if.active_count),
    .out_overflow     (out_if.overflow),
    .out_last         (out_if.last)
  );

endmodule

@@ rtl/spal_ram.sv @@
// ---------------------------------------------------------------------------
// spal_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module spal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/spal_dp.sv @@
// ---------------------------------------------------------------------------
// spal_dp
// Datapath: active list RAM, seen-pair RAM with per-row valid flags,
// index and size counters, and the output register.
// ---------------------------------------------------------------------------
module spal_dp #(
  parameter int MAX_OBJECTS  = 64,
  parameter int ACTIVE_SLOTS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  spal_pkg::cmd_t             cmd,
  output spal_pkg::status_t          sts,
  input  logic [1:0]                 in_op,
  input  logic [spal_pkg::OBJ_W-1:0] in_object_index,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [spal_pkg::OBJ_W-1:0] out_first_index,
  output logic [spal_pkg::OBJ_W-1:0] out_second_index,
  output logic [spal_pkg::CNT_W-1:0] out_active_count,
  output logic                       out_overflow,
  output logic                       out_last
);

  localparam int NOBJ    = (MAX_OBJECTS < spal_pkg::OBJ_RANGE) ? MAX_OBJECTS
                                                               : spal_pkg::OBJ_RANGE;
  localparam int ROW_AW  = (NOBJ > 1) ? $clog2(NOBJ) : 1;
  localparam int LIST_AW = (ACTIVE_SLOTS > 1) ? $clog2(ACTIVE_SLOTS) : 1;
  localparam int SZ_W    = $clog2(ACTIVE_SLOTS + 1);

  logic [1:0]                 op_r;
  logic [spal_pkg::OBJ_W-1:0] obj_r;
  logic [SZ_W-1:0]            idx_r;
  logic [SZ_W-1:0]            size_r;
  logic                       ovf_r;
  logic [spal_pkg::OBJ_W-1:0] other_r;
  logic                       other_ok_r;
  logic [ROW_AW-1:0]          lo_r;
  logic [ROW_AW-1:0]          hi_r;
  logic [NOBJ-1:0]            row_vld_r;

  logic                       out_valid_r;
  logic [spal_pkg::OBJ_W-1:0] first_r;
  logic [spal_pkg::OBJ_W-1:0] second_r;
  logic [spal_pkg::CNT_W-1:0] count_r;
  logic                       ovf_out_r;
  logic                       last_r;

  logic [SZ_W:0]              idx_p1;
  logic                       obj_ok;
  logic                       full;
  logic [spal_pkg::OBJ_W-1:0] list_q;
  logic                       list_we;
  logic [LIST_AW-1:0]         list_waddr;
  logic [LIST_AW-1:0]         list_raddr;
  logic [NOBJ-1:0]            seen_q;
  logic [NOBJ-1:0]            seen_eff;
  logic [NOBJ-1:0]            seen_wdata;
  logic                       seen_we;
  logic [spal_pkg::OBJ_W-1:0] pair_lo;
  logic [spal_pkg::OBJ_W-1:0] pair_hi;
  logic                       pair_emit;

  assign idx_p1 = {1'b0, idx_r} + (SZ_W + 1)'(1);
  assign obj_ok = (32'(obj_r) < 32'(MAX_OBJECTS));
  assign full   = (size_r == SZ_W'(ACTIVE_SLOTS));

  // active list
  assign list_we    = (cmd.append && !full) || cmd.shift_wr;
  assign list_waddr = cmd.shift_wr ? idx_r[LIST_AW-1:0] : size_r[LIST_AW-1:0];
  assign list_raddr = cmd.rd_next ? idx_p1[LIST_AW-1:0] : idx_r[LIST_AW-1:0];

  spal_ram #(
    .WIDTH (spal_pkg::OBJ_W),
    .DEPTH (ACTIVE_SLOTS)
  ) u_list_ram (
    .clk   (clk),
    .we    (list_we),
    .waddr (list_waddr),
    .wdata (cmd.shift_wr ? list_q : obj_r),
    .re    (cmd.list_rd),
    .raddr (list_raddr),
    .rdata (list_q)
  );

  // seen-pair store: row = lower index, bit = higher index
  assign pair_lo = (obj_r < list_q) ? obj_r : list_q;
  assign pair_hi = (obj_r < list_q) ? list_q : obj_r;

  // a row never written since the last clear reads as zero
  assign seen_eff   = row_vld_r[lo_r] ? seen_q : '0;
  assign seen_wdata = seen_eff | (NOBJ'(1) << hi_r);
  assign pair_emit  = cmd.pair_commit && other_ok_r && !seen_eff[hi_r];
  assign seen_we    = pair_emit;

  spal_ram #(
    .WIDTH (NOBJ),
    .DEPTH (NOBJ)
  ) u_seen_ram (
    .clk   (clk),
    .we    (seen_we),
    .waddr (lo_r),
    .wdata (seen_wdata),
    .re    (cmd.pair_latch),
    .raddr (pair_lo[ROW_AW-1:0]),
    .rdata (seen_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r    <= '0;
      row_vld_r <= '0;
      idx_r     <= '0;
      ovf_r     <= 1'b0;
    end else begin
      if (cmd.load_item) begin
        idx_r <= '0;
        ovf_r <= 1'b0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_p1[SZ_W-1:0];
      end
      if (cmd.clear_all) begin
        size_r    <= '0;
        row_vld_r <= '0;
      end else begin
        if (cmd.append) begin
          if (full) begin
            ovf_r <= 1'b1;
          end else begin
            size_r <= size_r + SZ_W'(1);
          end
        end else if (cmd.size_dec) begin
          size_r <= size_r - SZ_W'(1);
        end
        if (seen_we) begin
          row_vld_r[lo_r] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r  <= in_op;
      obj_r <= in_object_index;
    end
    if (cmd.pair_latch) begin
      other_r    <= list_q;
      other_ok_r <= (32'(list_q) < 32'(MAX_OBJECTS));
      lo_r       <= pair_lo[ROW_AW-1:0];
      hi_r       <= pair_hi[ROW_AW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pair_emit || cmd.emit_sum) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pair_emit) begin
      first_r   <= obj_r;
      second_r  <= other_r;
      count_r   <= '0;
      ovf_out_r <= 1'b0;
      last_r    <= 1'b0;
    end else if (cmd.emit_sum) begin
      first_r   <= '0;
      second_r  <= '0;
      count_r   <= spal_pkg::CNT_W'(size_r);
      ovf_out_r <= ovf_r;
      last_r    <= 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_first_index  = first_r;
  assign out_second_index = second_r;
  assign out_active_count = count_r;
  assign out_overflow     = ovf_out_r;
  assign out_last         = last_r;

  assign sts.is_start  = (op_r == spal_pkg::OP_START) && obj_ok;
  assign sts.is_end    = (op_r == spal_pkg::OP_END) && obj_ok;
  assign sts.is_clear  = (op_r == spal_pkg::OP_CLEAR);
  assign sts.more      = (idx_r < size_r);
  assign sts.next_more = (idx_p1 < {1'b0, size_r});
  assign sts.match     = (list_q == obj_r);
  assign sts.pair_new  = other_ok_r && !seen_eff[hi_r];
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule

@@ rtl/spal_ctrl.sv @@
// ---------------------------------------------------------------------------
// spal_ctrl
// Sequencer: walks the active list for start and end words, orders the
// pair and summary words onto the output register.
// ---------------------------------------------------------------------------
module spal_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  spal_pkg::status_t sts,
  output spal_pkg::cmd_t    cmd
);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_DISP   = 9'b000000010,
    ST_P_ROW  = 9'b000000100,
    ST_P_CHK  = 9'b000001000,
    ST_APPEND = 9'b000010000,
    ST_E_CMP  = 9'b000100000,
    ST_E_SHW  = 9'b001000000,
    ST_E_SHR  = 9'b010000000,
    ST_SUM    = 9'b100000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_DISP;
        end
      end
      ST_DISP: begin
        if (sts.is_clear) begin
          cmd.clear_all = 1'b1;
          state_nxt     = ST_SUM;
        end else if (sts.is_start) begin
          if (sts.more) begin
            cmd.list_rd = 1'b1;
            state_nxt   = ST_P_ROW;
          end else begin
            state_nxt = ST_APPEND;
          end
        end else if (sts.is_end && sts.more) begin
          cmd.list_rd = 1'b1;
          state_nxt   = ST_E_CMP;
        end else begin
          state_nxt = ST_SUM;
        end
      end
      ST_P_ROW: begin
        cmd.pair_latch = 1'b1;
        state_nxt      = ST_P_CHK;
      end
      ST_P_CHK: begin
        // hold while a new pair cannot be placed in the output register
        if (!sts.pair_new || sts.out_free) begin
          cmd.pair_commit = 1'b1;
          cmd.idx_inc     = 1'b1;
          if (sts.next_more) begin
            cmd.list_rd = 1'b1;
            cmd.rd_next = 1'b1;
            state_nxt   = ST_P_ROW;
          end else begin
            state_nxt = ST_APPEND;
          end
        end
      end
      ST_APPEND: begin
        cmd.append = 1'b1;
        state_nxt  = ST_SUM;
      end
      ST_E_CMP: begin
        if (sts.match) begin
          if (sts.next_more) begin
            cmd.list_rd = 1'b1;
            cmd.rd_next = 1'b1;
            state_nxt   = ST_E_SHW;
          end else begin
            cmd.size_dec = 1'b1;
            state_nxt    = ST_SUM;
          end
        end else begin
          cmd.idx_inc = 1'b1;
          if (sts.next_more) begin
            cmd.list_rd = 1'b1;
            cmd.rd_next = 1'b1;
            state_nxt   = ST_E_CMP;
          end else begin
            state_nxt = ST_SUM;
          end
        end
      end
      ST_E_SHW: begin
        cmd.shift_wr = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_nxt    = ST_E_SHR;
      end
      ST_E_SHR: begin
        if (sts.next_more) begin
          cmd.list_rd = 1'b1;
          cmd.rd_next = 1'b1;
          state_nxt   = ST_E_SHW;
        end else begin
          cmd.size_dec = 1'b1;
          state_nxt    = ST_SUM;
        end
      end
      ST_SUM: begin
        if (sts.out_free) begin
          cmd.emit_sum = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
